### src/event_sequence_checker_defines.svh
// Assertion macros of the event sequence checker, included by esc_core.
// Depends on nothing; the including module must provide clk and rst.
`ifndef EVENT_SEQUENCE_CHECKER_DEFINES_SVH
`define EVENT_SEQUENCE_CHECKER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define ESC_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define ESC_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

### src/esc_pkg.sv
// Shared types and constants of the event sequence checker.
// Used by esc_in_stage, esc_core and event_sequence_checker.
package esc_pkg;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [19:0] MICROS_MAX   = 20'd999999;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT     = 3'd0,
    VERDICT_NEW_RUN    = 3'd1,
    VERDICT_NO_HEADER  = 3'd2,
    VERDICT_NOT_RISING = 3'd3,
    VERDICT_TIME_BACK  = 3'd4
  } verdict_t;

  typedef struct packed {
    logic        header_present;
    logic [31:0] run_ident;
    logic [31:0] run_tag;
    logic [31:0] event_seq;
    logic [31:0] event_seconds;
    logic [19:0] event_micros;
  } item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        gap_over_second;
    logic [19:0] micros_step;
    logic [31:0] events_in_run;
    logic [19:0] step_min;
    logic [19:0] step_max;
    logic [47:0] step_sum;
    logic [31:0] expected_events;
    logic [31:0] run_span_seconds;
  } result_t;

endpackage

### src/esc_in_stage.sv
// Input register of the event sequence checker; clamps microseconds on arrival.
// Depends on esc_pkg.
module esc_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  esc_pkg::item_t       in_item,
  input  logic                 take,
  output logic                 valid,
  output esc_pkg::item_t       item
);

  esc_pkg::item_t item_next;

  // The stage refills in the same cycle that the core consumes it.
  assign in_ready = !valid || take;

  always_comb begin
    item_next = in_item;
    if (in_item.event_micros > esc_pkg::MICROS_MAX) begin
      item_next.event_micros = esc_pkg::MICROS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

### src/esc_core.sv
// Run state and per-event checks of the event sequence checker.
// Depends on esc_pkg and event_sequence_checker_defines.svh.
`include "event_sequence_checker_defines.svh"

module esc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  esc_pkg::item_t       item,
  input  logic                 advance,
  output esc_pkg::result_t     res
);

  logic [31:0] cur_run;
  logic [31:0] cur_tag;
  logic [31:0] first_number;
  logic [31:0] first_seconds;
  logic [31:0] prev_number;
  logic [31:0] prev_seconds;
  logic [19:0] prev_micros;
  logic [31:0] accepted_count;
  logic [19:0] min_step;
  logic [19:0] max_step;
  logic [47:0] sum_step;

  logic [31:0] cur_run_next;
  logic [31:0] cur_tag_next;
  logic [31:0] first_number_next;
  logic [31:0] first_seconds_next;
  logic [31:0] prev_number_next;
  logic [31:0] prev_seconds_next;
  logic [19:0] prev_micros_next;
  logic [31:0] accepted_count_next;
  logic [19:0] min_step_next;
  logic [19:0] max_step_next;
  logic [47:0] sum_step_next;

  logic               new_run;
  logic               accept;
  logic               has_step;
  esc_pkg::verdict_t  verdict;
  logic signed [32:0] sec_diff;
  logic [20:0]        us_diff;
  logic [19:0]        ustep;
  logic [48:0]        sum_add;
  logic [31:0]        count_base;

  assign new_run = (item.run_ident != cur_run) || (item.run_tag != cur_tag);

  always_comb begin
    accept = 1'b0;
    priority if (!item.header_present) begin
      verdict = esc_pkg::VERDICT_NO_HEADER;
    end else if (new_run) begin
      verdict = esc_pkg::VERDICT_NEW_RUN;
      accept  = 1'b1;
    end else if ($signed(item.event_seq) <= $signed(prev_number)) begin
      verdict = esc_pkg::VERDICT_NOT_RISING;
    end else if ($signed(item.event_seconds) < $signed(prev_seconds)) begin
      verdict = esc_pkg::VERDICT_TIME_BACK;
    end else begin
      verdict = esc_pkg::VERDICT_ACCEPT;
      accept  = 1'b1;
    end
  end

  // Seconds gap is taken on 33 bits so that it never wraps.
  assign sec_diff = $signed({item.event_seconds[31], item.event_seconds})
                  - $signed({prev_seconds[31], prev_seconds});
  assign us_diff  = {1'b0, item.event_micros} - {1'b0, prev_micros};
  assign ustep    = us_diff[20] ? (us_diff[19:0] + esc_pkg::USEC_PER_SEC) : us_diff[19:0];
  assign sum_add  = {1'b0, sum_step} + {29'd0, ustep};

  assign count_base = new_run ? 32'd0 : accepted_count;
  // A difference exists only when an earlier event of this run was accepted.
  assign has_step   = accept && !new_run && (accepted_count != 32'd0);

  always_comb begin
    cur_run_next        = cur_run;
    cur_tag_next        = cur_tag;
    first_number_next   = first_number;
    first_seconds_next  = first_seconds;
    prev_number_next    = prev_number;
    prev_seconds_next   = prev_seconds;
    prev_micros_next    = prev_micros;
    accepted_count_next = accepted_count;
    min_step_next       = min_step;
    max_step_next       = max_step;
    sum_step_next       = sum_step;

    if (accept) begin
      cur_run_next      = item.run_ident;
      cur_tag_next      = item.run_tag;
      prev_number_next  = item.event_seq;
      prev_seconds_next = item.event_seconds;
      prev_micros_next  = item.event_micros;
      accepted_count_next = (count_base == '1) ? count_base : count_base + 32'd1;
      if (new_run) begin
        first_number_next  = item.event_seq;
        first_seconds_next = item.event_seconds;
        min_step_next      = esc_pkg::USEC_PER_SEC;
        max_step_next      = 20'd0;
        sum_step_next      = 48'd0;
      end
    end

    if (has_step) begin
      sum_step_next = sum_add[48] ? '1 : sum_add[47:0];
      // A new minimum is deliberately not also checked against the maximum.
      if (ustep < min_step) begin
        min_step_next = ustep;
      end else if (ustep > max_step) begin
        max_step_next = ustep;
      end
    end
  end

  always_comb begin
    res.verdict          = verdict;
    res.gap_over_second  = has_step && (sec_diff > 33'sd1);
    res.micros_step      = has_step ? ustep : 20'd0;
    res.events_in_run    = accepted_count_next;
    res.step_min         = min_step_next;
    res.step_max         = max_step_next;
    res.step_sum         = sum_step_next;
    res.expected_events  = prev_number_next - first_number_next + 32'd1;
    res.run_span_seconds = prev_seconds_next - first_seconds_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_run        <= 32'd0;
      cur_tag        <= 32'd0;
      first_number   <= 32'd0;
      first_seconds  <= 32'd0;
      prev_number    <= 32'd0;
      prev_seconds   <= 32'd0;
      prev_micros    <= 20'd0;
      accepted_count <= 32'd0;
      min_step       <= esc_pkg::USEC_PER_SEC;
      max_step       <= 20'd0;
      sum_step       <= 48'd0;
    end else if (advance) begin
      cur_run        <= cur_run_next;
      cur_tag        <= cur_tag_next;
      first_number   <= first_number_next;
      first_seconds  <= first_seconds_next;
      prev_number    <= prev_number_next;
      prev_seconds   <= prev_seconds_next;
      prev_micros    <= prev_micros_next;
      accepted_count <= accepted_count_next;
      min_step       <= min_step_next;
      max_step       <= max_step_next;
      sum_step       <= sum_step_next;
    end
  end

  `ESC_ASSERT_NOW(a_min_in_range, 1'b1, min_step <= esc_pkg::USEC_PER_SEC, "min step out of range")
  `ESC_ASSERT_NOW(a_prev_micros_range, 1'b1, prev_micros <= esc_pkg::MICROS_MAX, "stored micros out of range")
  `ESC_ASSERT_NEXT(a_new_run_count, advance && accept && new_run, accepted_count == 32'd1, "new run count not one")
  `ESC_ASSERT_NEXT(a_reject_holds, advance && !accept, $stable(prev_number) && $stable(accepted_count) && $stable(cur_run), "rejected event changed state")
  `ESC_ASSERT_NOW(a_step_only_accept, res.micros_step != 20'd0, res.verdict == esc_pkg::VERDICT_ACCEPT, "step on non-accepted event")

endmodule

### src/event_sequence_checker.sv
// Event sequence checker: an event passes the input register, then the result register,
// which holds it with out_valid high until out_ready takes it.
// Throughput one event per cycle unless out_ready stalls it; the run state loop (compare,
// count, min/max, 48-bit saturating sum) is combinational between the two registers.
// Synchronous active-high reset empties both registers and returns the run state
// to run 0, tag 0, zero counts and a minimum step of 1000000; no clearing pass.
// Depends on esc_pkg, esc_in_stage and esc_core.
module event_sequence_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               header_present,
  input  logic [31:0]        run_ident,
  input  logic [31:0]        run_tag,
  input  logic signed [31:0] event_seq,
  input  logic signed [31:0] event_seconds,
  input  logic [19:0]        event_micros,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         verdict,
  output logic               gap_over_second,
  output logic [19:0]        micros_step,
  output logic [31:0]        events_in_run,
  output logic [19:0]        step_min,
  output logic [19:0]        step_max,
  output logic [47:0]        step_sum,
  output logic signed [31:0] expected_events,
  output logic signed [31:0] run_span_seconds
);

  esc_pkg::item_t   in_item;
  esc_pkg::item_t   stage_item;
  esc_pkg::result_t core_res;
  esc_pkg::result_t res;
  logic             stage_valid;
  logic             advance;

  assign in_item.header_present = header_present;
  assign in_item.run_ident      = run_ident;
  assign in_item.run_tag        = run_tag;
  assign in_item.event_seq      = event_seq;
  assign in_item.event_seconds  = event_seconds;
  assign in_item.event_micros   = event_micros;

  // An event moves into the result register whenever that register is free.
  assign advance = stage_valid && (!out_valid || out_ready);

  esc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (advance),
    .valid    (stage_valid),
    .item     (stage_item)
  );

  esc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .item    (stage_item),
    .advance (advance),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_res;
    end
  end

  assign verdict          = res.verdict;
  assign gap_over_second  = res.gap_over_second;
  assign micros_step      = res.micros_step;
  assign events_in_run    = res.events_in_run;
  assign step_min         = res.step_min;
  assign step_max         = res.step_max;
  assign step_sum         = res.step_sum;
  assign expected_events  = res.expected_events;
  assign run_span_seconds = res.run_span_seconds;

endmodule

### sim/esc_result_checker.sv
// Result checker for the event sequence checker: watches both channels, predicts each result.
// Depends on esc_pkg for the item, result and verdict types and the microsecond constants.
module esc_result_checker
  import esc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               header_present,
  input  logic [31:0]        run_ident,
  input  logic [31:0]        run_tag,
  input  logic signed [31:0] event_seq,
  input  logic signed [31:0] event_seconds,
  input  logic [19:0]        event_micros,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         verdict,
  input  logic               gap_over_second,
  input  logic [19:0]        micros_step,
  input  logic [31:0]        events_in_run,
  input  logic [19:0]        step_min,
  input  logic [19:0]        step_max,
  input  logic [47:0]        step_sum,
  input  logic signed [31:0] expected_events,
  input  logic signed [31:0] run_span_seconds,
  output int                 mismatch_count,
  output int                 backlog
);

  // Run state as the block should hold it.
  logic [31:0] run_id;
  logic [31:0] run_label;
  logic [31:0] first_num;
  logic [31:0] first_sec;
  logic [31:0] prev_num;
  logic [31:0] prev_sec;
  logic [19:0] prev_us;
  logic [31:0] run_count;
  logic [19:0] low_step;
  logic [19:0] high_step;
  logic [47:0] step_total;

  result_t awaited_results[$];
  int      fault_total;

  function automatic result_t judge_event(input item_t ev);
    result_t     r;
    logic [19:0] us;
    logic [19:0] ustep;
    logic        admit;
    logic        gap;
    longint      dsec;
    int          dus;
    us    = (ev.event_micros > MICROS_MAX) ? MICROS_MAX : ev.event_micros;
    ustep = '0;
    admit = 1'b0;
    gap   = 1'b0;
    if (!ev.header_present) begin
      r.verdict = VERDICT_NO_HEADER;
    end else if (ev.run_ident != run_id || ev.run_tag != run_label) begin
      run_count  = '0;
      step_total = '0;
      low_step   = USEC_PER_SEC;
      high_step  = '0;
      first_num  = ev.event_seq;
      first_sec  = ev.event_seconds;
      r.verdict  = VERDICT_NEW_RUN;
      admit      = 1'b1;
    end else if ($signed(ev.event_seq) <= $signed(prev_num)) begin
      r.verdict = VERDICT_NOT_RISING;
    end else if ($signed(ev.event_seconds) < $signed(prev_sec)) begin
      r.verdict = VERDICT_TIME_BACK;
    end else begin
      r.verdict = VERDICT_ACCEPT;
      admit     = 1'b1;
    end
    if (admit) begin
      if (run_count != '1) run_count = run_count + 32'd1;
      if (run_count > 32'd1) begin
        // The seconds gap is taken at full precision, so extremes cannot wrap.
        dsec = longint'($signed(ev.event_seconds)) - longint'($signed(prev_sec));
        gap  = (dsec > 1);
        dus  = int'(us) - int'(prev_us);
        if (dus < 0) dus = dus + int'(USEC_PER_SEC);
        ustep = dus[19:0];
        if (48'hFFFF_FFFF_FFFF - step_total < {28'd0, ustep}) step_total = '1;
        else step_total = step_total + {28'd0, ustep};
        // A new minimum skips the maximum test, as the block does.
        if (ustep < low_step) low_step = ustep;
        else if (ustep > high_step) high_step = ustep;
      end
      run_id    = ev.run_ident;
      run_label = ev.run_tag;
      prev_num  = ev.event_seq;
      prev_sec  = ev.event_seconds;
      prev_us   = us;
    end
    r.gap_over_second  = gap;
    r.micros_step      = ustep;
    r.events_in_run    = run_count;
    r.step_min         = low_step;
    r.step_max         = high_step;
    r.step_sum         = step_total;
    r.expected_events  = prev_num - first_num + 32'd1;
    r.run_span_seconds = prev_sec - first_sec;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_total++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    item_t   ev;
    if (rst) begin
      run_id      = '0;
      run_label   = '0;
      first_num   = '0;
      first_sec   = '0;
      prev_num    = '0;
      prev_sec    = '0;
      prev_us     = '0;
      run_count   = '0;
      low_step    = USEC_PER_SEC;
      high_step   = '0;
      step_total  = '0;
      fault_total = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        ev = '{header_present, run_ident, run_tag, event_seq, event_seconds,
               event_micros};
        awaited_results.push_back(judge_event(ev));
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no event waiting for one");
          fault_total++;
        end else begin
          want = awaited_results.pop_front();
          check_field("verdict", want.verdict, verdict);
          check_field("gap_over_second", want.gap_over_second, gap_over_second);
          check_field("micros_step", want.micros_step, micros_step);
          check_field("events_in_run", want.events_in_run, events_in_run);
          check_field("step_min", want.step_min, step_min);
          check_field("step_max", want.step_max, step_max);
          check_field("step_sum", want.step_sum, step_sum);
          check_field("expected_events", want.expected_events,
                      $unsigned(expected_events));
          check_field("run_span_seconds", want.run_span_seconds,
                      $unsigned(run_span_seconds));
        end
      end
    end
    mismatch_count <= fault_total;
    backlog        <= awaited_results.size();
  end

endmodule

### sim/tb_event_sequence_checker.sv
// Testbench top for event_sequence_checker: drives event headers, stalls the result side.
// Depends on esc_pkg, the block under test and esc_result_checker, which does the checking.
module tb_event_sequence_checker;
  import esc_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               header_present = 1'b0;
  logic [31:0]        run_ident = '0;
  logic [31:0]        run_tag = '0;
  logic signed [31:0] event_seq = '0;
  logic signed [31:0] event_seconds = '0;
  logic [19:0]        event_micros = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         verdict;
  logic               gap_over_second;
  logic [19:0]        micros_step;
  logic [31:0]        events_in_run;
  logic [19:0]        step_min;
  logic [19:0]        step_max;
  logic [47:0]        step_sum;
  logic signed [31:0] expected_events;
  logic signed [31:0] run_span_seconds;

  int mismatch_count;
  int backlog;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit squeeze = 1'b0;

  // Where the generator believes the current run stands.
  logic [31:0] gen_run = '0;
  logic [31:0] gen_tag = '0;
  int          gen_num = 0;
  int          gen_sec = 0;

  event_sequence_checker u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .header_present(header_present), .run_ident(run_ident), .run_tag(run_tag),
    .event_seq(event_seq), .event_seconds(event_seconds),
    .event_micros(event_micros),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .gap_over_second(gap_over_second), .micros_step(micros_step),
    .events_in_run(events_in_run), .step_min(step_min), .step_max(step_max),
    .step_sum(step_sum), .expected_events(expected_events),
    .run_span_seconds(run_span_seconds)
  );

  esc_result_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .header_present(header_present), .run_ident(run_ident), .run_tag(run_tag),
    .event_seq(event_seq), .event_seconds(event_seconds),
    .event_micros(event_micros),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .gap_over_second(gap_over_second), .micros_step(micros_step),
    .events_in_run(events_in_run), .step_min(step_min), .step_max(step_max),
    .step_sum(step_sum), .expected_events(expected_events),
    .run_span_seconds(run_span_seconds),
    .mismatch_count(mismatch_count), .backlog(backlog)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off once squeeze is raised.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !held) begin
        hold_left = 60;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic item_t mk(input logic hp, input logic [31:0] run, input logic [31:0] tag,
                               input logic [31:0] num, input logic [31:0] sec,
                               input logic [19:0] us);
    item_t it;
    it = '{hp, run, tag, num, sec, us};
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_event(input item_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    header_present <= ev.header_present;
    run_ident      <= ev.run_ident;
    run_tag        <= ev.run_tag;
    event_seq      <= ev.event_seq;
    event_seconds  <= ev.event_seconds;
    event_micros   <= ev.event_micros;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly well-formed continuations of the current run, the rest new runs and bad events.
  function automatic item_t next_event();
    item_t it;
    int    pick;
    int    r;
    pick = $urandom_range(99);
    it.header_present = 1'b1;
    if ($urandom_range(99) < 5) it.event_micros = 20'($urandom_range(20'hFFFFF, 1000000));
    else it.event_micros = 20'($urandom_range(999999));
    if (pick < 8) begin
      r = $urandom_range(3);
      case (r)
        0: begin
          gen_run = $urandom;
          gen_tag = $urandom;
        end
        1: gen_run = gen_run + 32'd1;
        2: gen_tag = gen_tag ^ (32'd1 << $urandom_range(31));
        default: begin
          gen_run = $urandom_range(3);
          gen_tag = $urandom_range(3);
        end
      endcase
      gen_num = ($urandom_range(9) == 0) ? int'($urandom) : int'($urandom_range(1000));
      gen_sec = ($urandom_range(9) == 0) ? int'($urandom) : int'($urandom_range(100000));
      it.event_seq     = gen_num;
      it.event_seconds = gen_sec;
    end else if (pick < 80) begin
      r = $urandom_range(99);
      gen_num = gen_num + int'($urandom_range(3, 1));
      if (r >= 90) gen_sec = gen_sec + int'($urandom_range(5, 2));
      else if (r >= 70) gen_sec = gen_sec + 1;
      it.event_seq     = gen_num;
      it.event_seconds = gen_sec;
    end else if (pick < 85) begin
      it.header_present = 1'b0;
      it.event_seq      = $urandom;
      it.event_seconds  = $urandom;
    end else if (pick < 90) begin
      it.event_seq     = gen_num - int'($urandom_range(3));
      it.event_seconds = gen_sec;
    end else if (pick < 95) begin
      it.event_seq     = gen_num + 1;
      it.event_seconds = gen_sec - int'($urandom_range(3, 1));
    end else begin
      it.header_present = 1'($urandom_range(1));
      it.event_seq      = $urandom;
      it.event_seconds  = $urandom;
      it.event_micros   = 20'($urandom);
    end
    it.run_ident = gen_run;
    it.run_tag   = gen_tag;
    if (pick >= 95) begin
      it.run_ident = $urandom;
      it.run_tag   = $urandom;
    end
    return it;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst           <= 1'b0;
    send_idle_pct <= 14;
    recv_idle_pct <= 71;

    // Run 0 tag 0 continues the reset run and is checked against zero history.
    send_event(mk(1'b1, 32'd0, 32'd0, 32'd5, 32'd10, 20'd100));
    // First step of the run sets the minimum and leaves the maximum at zero.
    send_event(mk(1'b1, 32'd0, 32'd0, 32'd6, 32'd10, 20'd300));
    // Gap of two seconds and a wrapped microsecond step.
    send_event(mk(1'b1, 32'd0, 32'd0, 32'd7, 32'd12, 20'd100));
    send_event(mk(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  20'hFFFFF));
    send_event(mk(1'b1, 32'd0, 32'd0, 32'd7, 32'd13, 20'd0));
    send_event(mk(1'b1, 32'd0, 32'd0, 32'd8, 32'd11, 20'd0));
    // Out-of-range microseconds are clipped on arrival.
    send_event(mk(1'b1, 32'd0, 32'd0, 32'd9, 32'd12, 20'hFFFFF));
    // Exactly one second apart is not a gap; a zero step is a new minimum.
    send_event(mk(1'b1, 32'd0, 32'd0, 32'd10, 32'd13, 20'd999999));
    send_event(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  20'd0));
    // Seconds span the whole signed range: the gap must not wrap.
    send_event(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF,
                  20'd1));
    send_event(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  20'd0));
    send_event(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  20'd5));
    send_event(mk(1'b1, 32'hFFFF_FFFF, 32'h0, 32'd0, 32'd0, 20'd5));
    send_event(mk(1'b1, 32'h0, 32'h0, 32'd1, 32'h8000_0000, 20'd999999));
    send_event(mk(1'b1, 32'h0, 32'h0, 32'd2, 32'h7FFF_FFFF, 20'd999998));
    send_event(mk(1'b1, 32'h0, 32'h0, 32'd2, 32'h7FFF_FFFF, 20'd7));
    send_event(mk(1'b1, 32'h0, 32'h0, 32'd3, 32'h7FFF_FFFE, 20'd7));

    repeat (470) send_event(next_event());
    send_idle_pct <= 71;
    recv_idle_pct <= 14;
    repeat (470) send_event(next_event());
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    squeeze       <= 1'b1;
    repeat (460) send_event(next_event());
    in_valid <= 1'b0;

    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && backlog == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
